FILE: hw/rtl/pgch_pkg.sv
// Shared types and constants for the pixel gain, clamp and histogram block.
// No dependencies; every other file of the block imports this package.
package pgch_pkg;

    localparam int PIXEL_W     = 32;
    localparam int GAIN_W      = 16;
    localparam int BRIGHT_W    = 11;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int BIN_W       = 8;
    localparam int NUM_BINS    = 256;
    localparam int CNT_OUT_W   = 21;
    localparam int COUNT_W_DEF = 21;

    // clamp limits and offset-binary conversion
    localparam int         CLAMP_LO    = -128;
    localparam int         CLAMP_HI    = 127;
    localparam logic [7:0] BYTE_OFFSET = 8'h80;
    localparam logic [7:0] BYTE_MAX    = 8'hFF;

    // reset values of the configuration registers
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd256;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd256;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ADJUST_ENABLE = 2'd0,
        REG_GAIN          = 2'd1,
        REG_BRIGHTNESS    = 2'd2,
        REG_HISTO_HEIGHT  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [PIXEL_W-1:0] pixel_value;
        logic [BIN_W-1:0]          bin_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]           display_byte;
        logic                 low_clip;
        logic                 high_clip;
        logic [HEIGHT_W-1:0]  bin_height;
        logic [CNT_OUT_W-1:0] bin_count;
    } t_out_item;

    // control from the sequencer to the bin store
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic             clear;
        logic [BIN_W-1:0] addr;
    } t_store_ctl;

endpackage

FILE: hw/rtl/pgch_bin_store.sv
// Histogram bin memory with one valid bit per bin, so a clear drops every bin at once.
// Depends on pgch_pkg for the bin count and the control struct.
module pgch_bin_store #(
    parameter int COUNT_WIDTH = pgch_pkg::COUNT_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pgch_pkg::t_store_ctl   i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_wr_data,
    output logic [COUNT_WIDTH-1:0] o_rd_data
);
    import pgch_pkg::*;

    logic [COUNT_WIDTH-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_hit;

    // write and registered read, one address per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.addr];
            r_rd_hit  <= r_valid[i_ctl.addr];
        end
    end

    // drop every bin at once on reset or clear; mark a bin once written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.addr] <= 1'b1;
        end
    end

    // a bin never written since the last clear reads as zero
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

FILE: hw/rtl/pixel_gain_clamp_histogram.sv
// Pixel gain, brightness and clamp with a 256-bin display histogram.
// Depends on pgch_pkg and pgch_bin_store.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one command per
// transaction: a pixel, a read of one scaled bin, or a clear. Every command
// gives exactly one result transaction on the output channel
// (o_out_valid / i_out_ready / o_out_data). Configuration registers are
// written through i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data, which
// is always ready; write them only while the block is idle.
// Items are handled one at a time under a small sequencer around one shared
// 33x17 multiplier, one bin memory port and a restoring divider that makes
// one quotient bit per cycle. Steps from acceptance to result:
//   pixel: multiply, scale and clamp, bin read, bin update, result
//   read: bin read, multiply, 16 divide steps (skipped while the largest count is zero), result
//   clear or unknown command: result only
// A new item is accepted in the cycle after the previous result is loaded.
// The result sits in an output register; a stalled receiver holds it there
// and the next item still runs, waiting only at its final step for the
// register to free up.
// Reset (synchronous, active low) empties all bins at once, zeroes the
// largest count and restores the register defaults.
module pixel_gain_clamp_histogram #(
    parameter int COUNT_WIDTH = pgch_pkg::COUNT_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pgch_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pgch_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [pgch_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pgch_pkg::*;

    localparam int MA_W = (COUNT_WIDTH >= PIXEL_W) ? COUNT_WIDTH + 1 : PIXEL_W + 1;
    localparam int MB_W = GAIN_W + 1;
    localparam int PW   = MA_W + MB_W;
    localparam int NW   = COUNT_WIDTH + HEIGHT_W + 2;
    localparam int SW   = $clog2(HEIGHT_W);
    localparam int VW   = PW - 7;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MUL     = 9'b000000010,
        S_SCALE   = 9'b000000100,
        S_RDMEM   = 9'b000001000,
        S_UPD     = 9'b000010000,
        S_LOADCNT = 9'b000100000,
        S_DIVINIT = 9'b001000000,
        S_DIV     = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    // configuration
    logic                       r_adjust;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [BRIGHT_W-1:0] r_bright;
    logic [HEIGHT_W-1:0]        r_height;

    // sequencer and datapath
    t_state                     r_state;
    logic [1:0]                 r_cmd;
    logic [BIN_W-1:0]           r_addr;
    logic signed [MA_W-1:0]     r_mul_a;
    logic signed [MB_W-1:0]     r_mul_b;
    logic signed [PW-1:0]       r_prod;
    logic [7:0]                 r_byte;
    logic                       r_lo;
    logic                       r_hi;
    logic [COUNT_WIDTH-1:0]     r_count;
    logic [COUNT_WIDTH-1:0]     r_largest;
    logic [NW-1:0]              r_rem;
    logic [NW-1:0]              r_dsh;
    logic [HEIGHT_W-1:0]        r_quot;
    logic [SW-1:0]              r_step;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic                       in_accept;
    logic                       out_free;
    t_store_ctl                 store_ctl;
    logic [COUNT_WIDTH-1:0]     store_rd_q;
    logic [COUNT_WIDTH-1:0]     store_rd;
    logic [COUNT_WIDTH-1:0]     cnt_inc;
    logic [HEIGHT_W-1:0]        hm1;
    logic signed [PW-1:0]       prod_rnd;
    logic signed [PW-9:0]       quo;
    logic signed [BRIGHT_W-1:0] bright_eff;
    logic signed [VW-1:0]       val;
    logic [7:0]                 byte_c;
    logic                       lo_c;
    logic                       hi_c;
    logic                       div_ge;
    logic [COUNT_WIDTH+CNT_OUT_W-1:0] cnt_wide;
    t_out_item                  n_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adjust <= 1'b0;
            r_gain   <= GAIN_RESET;
            r_bright <= '0;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ADJUST_ENABLE: r_adjust <= i_cfg_data[0];
                REG_GAIN:          r_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_BRIGHTNESS:    r_bright <= i_cfg_data[BRIGHT_W-1:0];
                REG_HISTO_HEIGHT:  r_height <= i_cfg_data[HEIGHT_W-1:0];
            endcase
        end
    end

    // bin store control
    always_comb begin
        store_ctl.rd_en = (r_state == S_RDMEM);
        store_ctl.wr_en = (r_state == S_UPD);
        store_ctl.clear = in_accept && (i_in_data.command == CMD_CLEAR);
        store_ctl.addr  = r_addr;
    end

    assign store_rd = (r_state == S_UPD || r_state == S_LOADCNT) ? store_rd_q : '0;

    pgch_bin_store #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (store_ctl),
        .i_wr_data(cnt_inc),
        .o_rd_data(store_rd_q)
    );

    // saturating bin increment
    assign cnt_inc = (&store_rd) ? store_rd : store_rd + 1'b1;

    // height of zero behaves as one
    assign hm1 = (r_height == '0) ? '0 : r_height - 1'b1;

    // truncate toward zero, add brightness, clamp to a display byte
    always_comb begin
        prod_rnd   = r_prod + $signed({{(PW-8){1'b0}}, {8{r_prod[PW-1]}}});
        quo        = prod_rnd[PW-1:8];
        bright_eff = r_adjust ? r_bright : '0;
        val        = $signed({quo[PW-9], quo})
                   + $signed({{(VW-BRIGHT_W){bright_eff[BRIGHT_W-1]}}, bright_eff});
        lo_c       = 1'b0;
        hi_c       = 1'b0;
        if (val < CLAMP_LO) begin
            byte_c = '0;
            lo_c   = r_adjust;
        end else if (val > CLAMP_HI) begin
            byte_c = BYTE_MAX;
            hi_c   = r_adjust;
        end else begin
            byte_c = val[7:0] + BYTE_OFFSET;
        end
    end

    assign div_ge = (r_rem >= r_dsh);

    // sequencer and shared datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_largest <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd   <= i_in_data.command;
                        r_addr  <= i_in_data.bin_index;
                        r_mul_a <= {{(MA_W-PIXEL_W){i_in_data.pixel_value[PIXEL_W-1]}},
                                    i_in_data.pixel_value};
                        r_mul_b <= r_adjust ? $signed({1'b0, r_gain})
                                            : $signed({1'b0, GAIN_RESET});
                        unique case (i_in_data.command)
                            CMD_PIXEL: r_state <= S_MUL;
                            CMD_READ:  r_state <= S_RDMEM;
                            CMD_CLEAR: begin
                                r_largest <= '0;
                                r_state   <= S_DONE;
                            end
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= r_mul_a * r_mul_b;
                    r_state <= (r_cmd == CMD_PIXEL) ? S_SCALE : S_DIVINIT;
                end
                S_SCALE: begin
                    r_byte  <= byte_c;
                    r_addr  <= byte_c;
                    r_lo    <= lo_c;
                    r_hi    <= hi_c;
                    r_state <= S_RDMEM;
                end
                S_RDMEM: begin
                    r_state <= (r_cmd == CMD_PIXEL) ? S_UPD : S_LOADCNT;
                end
                S_UPD: begin
                    if (cnt_inc > r_largest) begin
                        r_largest <= cnt_inc;
                    end
                    r_state <= S_DONE;
                end
                S_LOADCNT: begin
                    r_count <= store_rd;
                    r_mul_a <= $signed({{(MA_W-COUNT_WIDTH){1'b0}}, store_rd});
                    r_mul_b <= $signed({1'b0, hm1});
                    r_state <= S_MUL;
                end
                S_DIVINIT: begin
                    r_rem  <= {1'b0, r_prod[COUNT_WIDTH+HEIGHT_W-1:0], 1'b0}
                            + {{(NW-COUNT_WIDTH){1'b0}}, r_largest};
                    r_dsh  <= {2'b00, r_largest, {HEIGHT_W{1'b0}}};
                    r_quot <= '0;
                    r_step <= SW'(HEIGHT_W - 1);
                    r_state <= (r_largest == '0) ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_quot <= {r_quot[HEIGHT_W-2:0], div_ge};
                    r_dsh  <= r_dsh >> 1;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // assemble the result; unused fields stay zero
    always_comb begin
        cnt_wide = {{CNT_OUT_W{1'b0}}, r_count};
        n_out    = '0;
        unique case (r_cmd)
            CMD_PIXEL: begin
                n_out.display_byte = r_byte;
                n_out.low_clip     = r_lo;
                n_out.high_clip    = r_hi;
            end
            CMD_READ: begin
                n_out.bin_height = r_quot;
                n_out.bin_count  = cnt_wide[CNT_OUT_W-1:0];
            end
            default: n_out = '0;
        endcase
    end

    // output register: load at the final step, release on transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= n_out;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: dv/pgch_checker.sv
`timescale 1ns / 1ps
// Checker for pixel_gain_clamp_histogram: watches the command, result and register channels,
// keeps its own copy of the bins and registers, and compares every result transaction.
// Depends on pgch_pkg.
module pgch_checker #(
    parameter int COUNT_WIDTH = pgch_pkg::COUNT_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  pgch_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  pgch_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [pgch_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import pgch_pkg::*;

    // shadow of the histogram and the register file
    logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];
    logic [COUNT_WIDTH-1:0] peak_tally;
    logic                   adj_en;
    logic [GAIN_W-1:0]      gain_q88;
    logic signed [BRIGHT_W-1:0] bright_ofs;
    logic [HEIGHT_W-1:0]    height_span;

    t_out_item due_results [$];
    int        fail_total = 0;

    // Work out the result of one command and advance the shadow histogram.
    function automatic t_out_item apply_command(t_in_item cmd);
        t_out_item              res;
        longint                 level;
        logic [7:0]             disp;
        logic [COUNT_WIDTH-1:0] tally;
        longint unsigned        cnt;
        longint unsigned        span;
        longint unsigned        peak;
        res = '0;
        case (cmd.command)
            CMD_PIXEL: begin
                level = longint'($signed(cmd.pixel_value));
                if (adj_en) begin
                    // signed division truncates toward zero
                    level = (level * longint'(gain_q88)) / 256;
                    level = level + longint'(bright_ofs);
                end
                if (level < CLAMP_LO) begin
                    disp = '0;
                    res.low_clip = adj_en;
                end else if (level > CLAMP_HI) begin
                    disp = BYTE_MAX;
                    res.high_clip = adj_en;
                end else begin
                    disp = 8'(level) + BYTE_OFFSET;
                end
                res.display_byte = disp;
                // bins stop at full scale; the peak follows the tallest bin
                tally = bin_tally[disp];
                if (tally != '1) tally = tally + 1'b1;
                bin_tally[disp] = tally;
                if (tally > peak_tally) peak_tally = tally;
            end
            CMD_READ: begin
                cnt  = bin_tally[cmd.bin_index];
                peak = peak_tally;
                span = (height_span == 0) ? 1 : height_span;
                if (peak != 0) begin
                    res.bin_height = HEIGHT_W'((2 * cnt * (span - 1) + peak) / (2 * peak));
                end
                res.bin_count = CNT_OUT_W'(cnt);
            end
            CMD_CLEAR: begin
                foreach (bin_tally[i]) bin_tally[i] = '0;
                peak_tally = '0;
            end
            default: begin
                // unknown command: no state change, all-zero result
            end
        endcase
        return res;
    endfunction

    function automatic void match_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            peak_tally  = '0;
            adj_en      = 1'b0;
            gain_q88    = GAIN_RESET;
            bright_ofs  = '0;
            height_span = HEIGHT_RESET;
            due_results.delete();
        end else begin
            // compare the result transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    fail_total++;
                end else begin
                    want = due_results.pop_front();
                    match_field("display_byte", want.display_byte, i_out_data.display_byte);
                    match_field("low_clip", want.low_clip, i_out_data.low_clip);
                    match_field("high_clip", want.high_clip, i_out_data.high_clip);
                    match_field("bin_height", want.bin_height, i_out_data.bin_height);
                    match_field("bin_count", want.bin_count, i_out_data.bin_count);
                end
            end
            // track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ADJUST_ENABLE: adj_en      = i_cfg_data[0];
                    REG_GAIN:          gain_q88    = i_cfg_data[GAIN_W-1:0];
                    REG_BRIGHTNESS:    bright_ofs  = i_cfg_data[BRIGHT_W-1:0];
                    REG_HISTO_HEIGHT:  height_span = i_cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            // predict each accepted command
            if (i_in_valid && i_in_ready) begin
                due_results.push_back(apply_command(i_in_data));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= due_results.size();
    end

endmodule

FILE: dv/tb_pixel_gain_clamp_histogram.sv
`timescale 1ns / 1ps
// Testbench top for pixel_gain_clamp_histogram: drives commands and register writes,
// throttles the result channel, and gives the verdict from the failure and pending counts of pgch_checker.
// Depends on pgch_pkg, pgch_checker and the block itself.
module tb_pixel_gain_clamp_histogram;
    import pgch_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 215;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 30;
    localparam longint     RUN_LIMIT_NS = 5_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    bit tx_steady;
    bit long_hold;

    pixel_gain_clamp_histogram DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pgch_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_in_item make_cmd(logic [1:0] code, logic [31:0] px, logic [7:0] idx);
        t_in_item it;
        it.command     = code;
        it.pixel_value = px;
        it.bin_index   = idx;
        return it;
    endfunction

    // mostly values near the clamp window, some across the full range
    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5, 6: return 32'($urandom_range(0, 600)) - 32'd300;
            default: return 32'($urandom_range(0, 4000)) - 32'd2000;
        endcase
    endfunction

    function automatic t_in_item rand_command();
        t_in_item it;
        int       pick;
        it   = make_cmd(CMD_PIXEL, $urandom, 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 74) begin
            it.pixel_value = rand_pixel();
        end else if (pick < 95) begin
            it.command = CMD_READ;
        end else if (pick < 97) begin
            it.command = CMD_CLEAR;
        end else begin
            it.command = CMD_UNKNOWN;
        end
        return it;
    endfunction

    // offer one command transaction after a random gap, hold until accepted
    task automatic offer_command(t_in_item it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_data  = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // write all four registers; unused upper bits carry noise
    task automatic write_regs(logic adj, logic [15:0] gain, logic [10:0] bright,
                              logic [15:0] height);
        logic [15:0] noise;
        noise = 16'($urandom);
        write_reg(REG_ADJUST_ENABLE, {noise[15:1], adj});
        write_reg(REG_GAIN, gain);
        write_reg(REG_BRIGHTNESS, {noise[15:11], bright});
        write_reg(REG_HISTO_HEIGHT, height);
    endtask

    // result side: random stalls, steady stretches, and one long hold on request
    initial begin : receiver
        int gap;
        int taken;
        bit rx_steady;
        out_ready = 1'b0;
        taken     = 0;
        rx_steady = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, 12);
            if (long_hold) begin
                long_hold = 1'b0;
                gap       = LONG_HOLD;
            end
            repeat (gap) begin
                @(negedge clk);
                out_ready = 1'b0;
            end
            @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken++;
            if (taken % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stimulus
        logic [15:0] gain;
        logic [10:0] bright;
        logic [15:0] height;
        logic        adj;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tx_steady = 1'b0;
        long_hold = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: clamp only, flags stay low
        offer_command(make_cmd(CMD_PIXEL, 32'h8000_0000, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, 32'h7FFF_FFFF, 8'hFF));
        offer_command(make_cmd(CMD_PIXEL, -129, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, -128, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, 127, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, 128, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, 0, 8'h00));
        offer_command(make_cmd(CMD_READ, 32'hFFFF_FFFF, 8'h80));
        offer_command(make_cmd(CMD_READ, 32'h0, 8'hFF));
        offer_command(make_cmd(CMD_READ, 32'h0, 8'h00));
        offer_command(make_cmd(CMD_UNKNOWN, 32'h1234_5678, 8'h5A));

        // unity gain with flags, then clear and read an empty histogram
        settle();
        write_regs(1'b1, 16'd256, 11'd0, 16'd256);
        offer_command(make_cmd(CMD_PIXEL, 32'h8000_0000, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, 32'h7FFF_FFFF, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, -129, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, 128, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, 5, 8'h00));
        offer_command(make_cmd(CMD_READ, 32'h0, 8'hFF));
        offer_command(make_cmd(CMD_CLEAR, 32'hA5A5_A5A5, 8'hC3));
        offer_command(make_cmd(CMD_READ, 32'h0, 8'hFF));

        // largest gain with most negative brightness
        settle();
        write_regs(1'b1, 16'hFFFF, 11'h400, 16'd256);
        offer_command(make_cmd(CMD_PIXEL, 1, 8'h00));
        offer_command(make_cmd(CMD_PIXEL, -1, 8'h00));

        // zero gain, most positive brightness, height of zero
        settle();
        write_regs(1'b1, 16'd0, 11'h3FF, 16'd0);
        offer_command(make_cmd(CMD_PIXEL, 12345, 8'h00));
        offer_command(make_cmd(CMD_READ, 32'h0, 8'hFF));

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            settle();
            adj = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == 1) begin
                gain   = 16'hFFFF;
                bright = 11'h400;
                height = 16'd1;
            end else if (p == 2) begin
                gain   = 16'd0;
                bright = 11'h3FF;
                height = 16'hFFFF;
            end else if (p == 3) begin
                gain   = 16'd256;
                bright = 11'd0;
                height = 16'd256;
            end else begin
                gain   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(64, 1024))
                                                     : 16'($urandom);
                bright = 11'($urandom_range(0, 200)) - 11'd100;
                height = 16'($urandom_range(1, 65535));
            end
            write_regs(adj, gain, bright, height);
            tx_steady = ($urandom_range(0, 3) == 0);
            // let the result side back up and stall the block
            if (p == 1 || p == 5) long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer_command(rand_command());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
